@@ design/gray16_to_gray8_minmax_stretch_core_defines.svh @@
`ifndef GRAY16_TO_GRAY8_MINMAX_STRETCH_CORE_DEFINES_SVH
`define GRAY16_TO_GRAY8_MINMAX_STRETCH_CORE_DEFINES_SVH

// property that holds at every edge out of reset
`define GMMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication into the next cycle
`define GMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/gmms_pkg.sv @@
package gmms_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 65536;
  localparam int unsigned MAX_WIDTH_DEF  = 4096;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [12:0] FRAME_WIDTH_RST = 13'd640;
  localparam logic [15:0] MIN_RST         = 16'hFFFF;
  localparam logic [7:0]  LEVEL_FULL      = 8'd255;

  localparam int unsigned NUM_W     = 24;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned Q_DEPTH   = 2;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH,
    REG_AREA_LEFT,
    REG_AREA_TOP,
    REG_AREA_WIDTH,
    REG_AREA_HEIGHT,
    REG_USE_GIVEN,
    REG_GIVEN_RANGE,
    REG_BG_LEVEL
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] pixel_in;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [11:0] area_left;
    logic [15:0] area_top;
    logic [12:0] area_width;
    logic [16:0] area_height;
    logic        use_given_range;
    logic [31:0] given_range;
    logic [7:0]  bg_level;
  } cfg_t;

  typedef struct packed {
    logic        need_div;
    logic [7:0]  px;
    logic [15:0] v;
    logic [15:0] mn;
    logic [15:0] mx;
    logic        last;
  } work_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_POS,
    FE_READ
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_MUL,
    BE_DIV,
    BE_OUT
  } be_state_e;

endpackage

@@ design/gmms_front.sv @@
module gmms_front #(
  parameter int unsigned MAX_PIXELS = gmms_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_WIDTH  = gmms_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gmms_pkg::cfg_t     cfg_i,
  input  logic               width_wr_i,
  input  logic               push_i,
  input  gmms_pkg::in_item_t item_i,
  output logic               full_o,
  input  logic               wk_room_i,
  output logic               wk_valid_o,
  output gmms_pkg::work_t    wk_o
);

  localparam int unsigned AW   = $clog2(MAX_PIXELS);
  localparam int unsigned CW   = $clog2(MAX_PIXELS + 1);
  localparam int unsigned XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CNTW = $clog2(AW + 1);

  gmms_pkg::fe_state_e state_q, state_d;

  logic [15:0] frame_store_q [MAX_PIXELS];
  logic [15:0] rd_q;

  logic [CW-1:0]   load_cnt_q, load_cnt_d;
  logic [XW-1:0]   lcol_q, lcol_d, ecol_q, ecol_d;
  logic [15:0]     lrow_q, lrow_d;
  logic [AW-1:0]   emit_q, emit_d, erow_q, erow_d, dq_q, dq_d;
  logic [15:0]     min_q, min_d, max_q, max_d;
  logic            ready_q, ready_d, stale_q, stale_d;
  logic [12:0]     rem_q, rem_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  logic [12:0]   w;
  logic          accept, is_load, wr_en, in_scan, in_emit, whole;
  logic [CW-1:0] lc_b;
  logic [XW-1:0] lcol_b;
  logic [15:0]   lrow_b, min_b, max_b, mn, mx;
  logic [29:0]   area_span;
  logic [13:0]   rem_sh;
  logic          qbit;
  logic [12:0]   rem_n;

  function automatic logic in_area(gmms_pkg::cfg_t c, logic [31:0] col, logic [31:0] row);
    logic nul;
    nul = (c.area_width == '0) && (c.area_height == '0);
    in_area = nul || (col >= 32'(c.area_left) &&
                      col < 32'(c.area_left) + 32'(c.area_width) &&
                      row >= 32'(c.area_top) &&
                      row < 32'(c.area_top) + 32'(c.area_height));
  endfunction

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w = 13'd1;
    end else if (32'(cfg_i.frame_width) > MAX_WIDTH) begin
      w = 13'(MAX_WIDTH);
    end else begin
      w = cfg_i.frame_width;
    end
  end

  assign full_o  = (state_q != gmms_pkg::FE_IDLE) || !wk_room_i;
  assign accept  = push_i && !full_o;
  assign is_load = (item_i.operation == gmms_pkg::OP_LOAD);

  // a load after a complete frame starts a new one
  assign lc_b   = ready_q ? '0 : load_cnt_q;
  assign lcol_b = ready_q ? '0 : lcol_q;
  assign lrow_b = ready_q ? '0 : lrow_q;
  assign min_b  = ready_q ? gmms_pkg::MIN_RST : min_q;
  assign max_b  = ready_q ? '0 : max_q;

  // rows begun at the present width equal the rectangle height when
  // (height - 1) * width < count <= height * width
  assign area_span = 30'(cfg_i.area_height) * 30'(w);

  assign wr_en   = accept && is_load && (32'(lc_b) < MAX_PIXELS);
  assign in_scan = in_area(cfg_i, 32'(lcol_b), 32'(lrow_b));
  assign in_emit = in_area(cfg_i, 32'(ecol_q), 32'(erow_q));
  assign whole   = ((cfg_i.area_width == '0) && (cfg_i.area_height == '0)) ||
                   (cfg_i.area_left == '0 && cfg_i.area_top == '0 &&
                    cfg_i.area_width == w && cfg_i.area_height != '0 &&
                    area_span >= 30'(load_cnt_q) &&
                    area_span - 30'(w) < 30'(load_cnt_q));

  assign mn = cfg_i.use_given_range ? cfg_i.given_range[15:0]  : min_q;
  assign mx = cfg_i.use_given_range ? cfg_i.given_range[31:16] : max_q;

  assign rem_sh = {rem_q, dq_q[AW-1]};
  assign qbit   = (rem_sh >= {1'b0, w});
  assign rem_n  = qbit ? 13'(rem_sh - {1'b0, w}) : rem_sh[12:0];

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    lcol_d     = lcol_q;
    lrow_d     = lrow_q;
    emit_d     = emit_q;
    ecol_d     = ecol_q;
    erow_d     = erow_q;
    min_d      = min_q;
    max_d      = max_q;
    ready_d    = ready_q;
    stale_d    = stale_q || width_wr_i;
    rem_d      = rem_q;
    dq_d       = dq_q;
    cnt_d      = cnt_q;
    wk_valid_o = 1'b0;
    wk_o       = '0;
    case (state_q)
      gmms_pkg::FE_IDLE: begin
        if (accept && is_load) begin
          load_cnt_d = lc_b;
          lcol_d     = lcol_b;
          lrow_d     = lrow_b;
          min_d      = min_b;
          max_d      = max_b;
          if (ready_q) begin
            emit_d  = '0;
            ecol_d  = '0;
            erow_d  = '0;
            stale_d = 1'b0;
          end
          if (wr_en) begin
            if (in_scan && item_i.pixel_in < min_b) min_d = item_i.pixel_in;
            if (in_scan && item_i.pixel_in > max_b) max_d = item_i.pixel_in;
            load_cnt_d = lc_b + 1'b1;
            if (32'(lcol_b) + 32'd1 >= 32'(w)) begin
              lcol_d = '0;
              lrow_d = lrow_b + 16'd1;
            end else begin
              lcol_d = lcol_b + 1'b1;
            end
          end
          ready_d = item_i.frame_end;
        end else if (accept && ready_q && load_cnt_q != '0) begin
          if (stale_q && emit_q != '0) begin
            state_d = gmms_pkg::FE_POS;
            dq_d    = emit_q;
            rem_d   = '0;
            cnt_d   = '0;
          end else begin
            state_d = gmms_pkg::FE_READ;
          end
        end
      end
      gmms_pkg::FE_POS: begin
        rem_d = rem_n;
        dq_d  = {dq_q[AW-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == AW - 1) begin
          ecol_d  = XW'(rem_n);
          erow_d  = {dq_q[AW-2:0], qbit};
          stale_d = 1'b0;
          state_d = gmms_pkg::FE_READ;
        end
      end
      gmms_pkg::FE_READ: begin
        wk_valid_o  = 1'b1;
        wk_o.v      = rd_q;
        wk_o.mn     = mn;
        wk_o.mx     = mx;
        wk_o.last   = (32'(emit_q) + 32'd1 == 32'(load_cnt_q));
        if (mn == mx) begin
          wk_o.need_div = 1'b0;
          wk_o.px = (whole || in_emit) ? ((mn != '0) ? gmms_pkg::LEVEL_FULL : '0)
                                       : cfg_i.bg_level;
        end else begin
          wk_o.need_div = in_emit;
          wk_o.px       = rd_q[7:0];
        end
        if (32'(emit_q) + 32'd1 >= 32'(load_cnt_q)) begin
          emit_d = '0;
          ecol_d = '0;
          erow_d = '0;
        end else begin
          emit_d = emit_q + 1'b1;
          if (32'(ecol_q) + 32'd1 >= 32'(w)) begin
            ecol_d = '0;
            erow_d = erow_q + 1'b1;
          end else begin
            ecol_d = ecol_q + 1'b1;
          end
        end
        state_d = gmms_pkg::FE_IDLE;
      end
      default: state_d = gmms_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) frame_store_q[lc_b[AW-1:0]] <= item_i.pixel_in;
    rd_q  <= frame_store_q[emit_q];
    rem_q <= rem_d;
    dq_q  <= dq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gmms_pkg::FE_IDLE;
      load_cnt_q <= '0;
      lcol_q     <= '0;
      lrow_q     <= '0;
      emit_q     <= '0;
      ecol_q     <= '0;
      erow_q     <= '0;
      min_q      <= gmms_pkg::MIN_RST;
      max_q      <= '0;
      ready_q    <= 1'b0;
      stale_q    <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      lcol_q     <= lcol_d;
      lrow_q     <= lrow_d;
      emit_q     <= emit_d;
      ecol_q     <= ecol_d;
      erow_q     <= erow_d;
      min_q      <= min_d;
      max_q      <= max_d;
      ready_q    <= ready_d;
      stale_q    <= stale_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

@@ design/gmms_queue.sv @@
module gmms_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gmms_pkg::work_t data_i,
  output logic            room_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gmms_pkg::work_t data_o
);

  localparam int unsigned PW = $clog2(gmms_pkg::Q_DEPTH);

  gmms_pkg::work_t entry_q [gmms_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;
  logic            do_push, do_pop;

  assign room_o  = (32'(cnt_q) < gmms_pkg::Q_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_q];
  assign do_push = push_i && room_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

@@ design/gmms_back.sv @@
`include "gray16_to_gray8_minmax_stretch_core_defines.svh"

module gmms_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wk_valid_i,
  input  gmms_pkg::work_t     wk_i,
  output logic                wk_pop_o,
  input  logic                pop,
  output logic                empty,
  output gmms_pkg::out_item_t out_item_o
);

  localparam int unsigned SW = $clog2(gmms_pkg::DIV_STEPS);

  gmms_pkg::be_state_e state_q, state_d;
  gmms_pkg::work_t     work_q, work_d;

  logic [gmms_pkg::NUM_W-1:0] nq_q, nq_d;
  logic [15:0]   dm_q, dm_d, rem_q, rem_d;
  logic          neg_q, neg_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [7:0]    res_q, res_d;
  logic          out_valid_q, out_valid_d, out_load;
  gmms_pkg::out_item_t out_q;

  logic signed [16:0] diff, den;
  logic signed [24:0] diff_x, num;
  logic [16:0]        rem_sh;
  logic               ge;
  logic [gmms_pkg::NUM_W-1:0] nq_n;

  assign diff   = $signed({1'b0, work_q.v}) - $signed({1'b0, work_q.mn});
  assign den    = $signed({1'b0, work_q.mx}) - $signed({1'b0, work_q.mn});
  assign diff_x = {{8{diff[16]}}, diff};
  assign num    = (diff_x <<< 8) - diff_x;

  assign rem_sh = {rem_q, nq_q[gmms_pkg::NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dm_q});
  assign nq_n   = {nq_q[gmms_pkg::NUM_W-2:0], ge};

  assign out_load = (state_q == gmms_pkg::BE_OUT) && (!out_valid_q || pop);

  always_comb begin
    state_d  = state_q;
    work_d   = work_q;
    nq_d     = nq_q;
    dm_d     = dm_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    res_d    = res_q;
    wk_pop_o = 1'b0;
    case (state_q)
      gmms_pkg::BE_IDLE: begin
        if (wk_valid_i) begin
          wk_pop_o = 1'b1;
          work_d   = wk_i;
          res_d    = wk_i.px;
          state_d  = wk_i.need_div ? gmms_pkg::BE_MUL : gmms_pkg::BE_OUT;
        end
      end
      gmms_pkg::BE_MUL: begin
        nq_d    = num[24] ? gmms_pkg::NUM_W'(-num) : num[gmms_pkg::NUM_W-1:0];
        dm_d    = den[16] ? 16'(-den) : den[15:0];
        neg_d   = num[24] ^ den[16];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = gmms_pkg::BE_DIV;
      end
      gmms_pkg::BE_DIV: begin
        rem_d = ge ? 16'(rem_sh - {1'b0, dm_q}) : rem_sh[15:0];
        nq_d  = nq_n;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == gmms_pkg::DIV_STEPS - 1) begin
          res_d   = neg_q ? 8'(-nq_n[7:0]) : nq_n[7:0];
          state_d = gmms_pkg::BE_OUT;
        end
      end
      gmms_pkg::BE_OUT: begin
        if (out_load) state_d = gmms_pkg::BE_IDLE;
      end
      default: state_d = gmms_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    nq_q   <= nq_d;
    dm_q   <= dm_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q.pixel_out <= res_q;
      out_q.last_out  <= work_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmms_pkg::BE_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `GMMS_ASSERT(a_den_nonzero, (state_q != gmms_pkg::BE_MUL) || (work_q.mx != work_q.mn), "zero divisor")
  `GMMS_ASSERT(a_step_range, (state_q != gmms_pkg::BE_DIV) || (32'(cnt_q) < gmms_pkg::DIV_STEPS), "step overrun")
  `GMMS_ASSERT_NEXT(a_out_loaded, out_load, out_valid_q, "result lost")

endmodule

@@ design/gray16_to_gray8_minmax_stretch_core.sv @@
// 16-bit to 8-bit min/max contrast stretch. Load items (operation 0) write a frame in raster
// order into an on-chip store of MAX_PIXELS words and track min/max inside the work rectangle;
// a load is taken every cycle while the front part is idle and the item queue has room. Once a
// frame_end load has completed the frame, each request item (operation 1) returns one 8-bit pixel
// in raster order, wrapping to the first pixel after the last. A request passes the front part
// (store read); the first request at a nonzero position after frame_width was rewritten first
// rebuilds the row/column position with a restoring divider. Rectangle pixels of a frame whose
// min and max differ then pass a bit-serial 24-step divider in the back part, which limits the
// sustained request rate; other pixels skip it. A two-entry item queue lies between front and
// back, and a result register drives the output side. Registers sit at byte address 4*index on
// the APB port and must be written only while the block is idle; the block does not enforce it.
module gray16_to_gray8_minmax_stretch_core #(
  parameter int unsigned MAX_PIXELS = gmms_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_WIDTH  = gmms_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  gmms_pkg::in_item_t            in_item_i,
  input  logic                          pop,
  output logic                          empty,
  output gmms_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmms_pkg::CFG_AW-1:0]   paddr,
  input  logic [gmms_pkg::CFG_DW-1:0]   pwdata,
  output logic [gmms_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  gmms_pkg::cfg_t     cfg_q, cfg_d;
  gmms_pkg::reg_idx_e reg_idx;
  logic               wr, width_wr;

  logic            wk_valid, wk_room, q_valid, q_pop;
  gmms_pkg::work_t wk, q_data;

  assign pready   = 1'b1;
  assign reg_idx  = gmms_pkg::reg_idx_e'(paddr[4:2]);
  assign wr       = psel && penable && pwrite && pready;
  assign width_wr = wr && (reg_idx == gmms_pkg::REG_FRAME_WIDTH);

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (reg_idx)
        gmms_pkg::REG_FRAME_WIDTH: cfg_d.frame_width     = pwdata[12:0];
        gmms_pkg::REG_AREA_LEFT:   cfg_d.area_left       = pwdata[11:0];
        gmms_pkg::REG_AREA_TOP:    cfg_d.area_top        = pwdata[15:0];
        gmms_pkg::REG_AREA_WIDTH:  cfg_d.area_width      = pwdata[12:0];
        gmms_pkg::REG_AREA_HEIGHT: cfg_d.area_height     = pwdata[16:0];
        gmms_pkg::REG_USE_GIVEN:   cfg_d.use_given_range = pwdata[0];
        gmms_pkg::REG_GIVEN_RANGE: cfg_d.given_range     = pwdata;
        gmms_pkg::REG_BG_LEVEL:    cfg_d.bg_level        = pwdata[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gmms_pkg::REG_FRAME_WIDTH: prdata = 32'(cfg_q.frame_width);
      gmms_pkg::REG_AREA_LEFT:   prdata = 32'(cfg_q.area_left);
      gmms_pkg::REG_AREA_TOP:    prdata = 32'(cfg_q.area_top);
      gmms_pkg::REG_AREA_WIDTH:  prdata = 32'(cfg_q.area_width);
      gmms_pkg::REG_AREA_HEIGHT: prdata = 32'(cfg_q.area_height);
      gmms_pkg::REG_USE_GIVEN:   prdata = 32'(cfg_q.use_given_range);
      gmms_pkg::REG_GIVEN_RANGE: prdata = cfg_q.given_range;
      gmms_pkg::REG_BG_LEVEL:    prdata = 32'(cfg_q.bg_level);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gmms_pkg::cfg_t'{frame_width: gmms_pkg::FRAME_WIDTH_RST, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gmms_front #(
    .MAX_PIXELS(MAX_PIXELS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .width_wr_i(width_wr),
    .push_i    (push),
    .item_i    (in_item_i),
    .full_o    (full),
    .wk_room_i (wk_room),
    .wk_valid_o(wk_valid),
    .wk_o      (wk)
  );

  gmms_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (wk_valid),
    .data_i (wk),
    .room_o (wk_room),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  gmms_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wk_valid_i(q_valid),
    .wk_i      (q_data),
    .wk_pop_o  (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item_o(out_item_o)
  );

endmodule
